>>> src/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro samples on i_clk; the plain form is held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside reset
`define RDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset included
`define RDC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> src/rdc_pkg.sv
package rdc_pkg;

    // Drive phase reported with each result word
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_DELAY = 3'd1,
        PH_REACT = 3'd2,
        PH_TURN  = 3'd3,
        PH_REV   = 3'd4,
        PH_SPIN  = 3'd5
    } t_phase;

    // Four motor leg duties: [0] left fwd, [1] left rev, [2] right fwd, [3] right rev
    typedef logic [3:0][7:0] t_duty;

    localparam int DUTY_W   = 8;
    localparam int IR_W     = 10;
    localparam int TIME_W   = 16;
    localparam int TICK_W   = 32;
    localparam int CODE_W   = 7;
    localparam int CFG_IDX_W = 3;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 40;

    // Duty levels
    localparam logic [7:0] DUTY_OFF        = 8'd0;
    localparam logic [7:0] DUTY_FULL       = 8'd255;
    localparam logic [7:0] DUTY_WEAVE_SLOW = 8'd150;
    localparam logic [7:0] DUTY_VEER_SLOW  = 8'd155;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_IR_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_START_DELAY  = 3'd1;
    localparam logic [2:0] REG_TURN_TIME    = 3'd2;
    localparam logic [2:0] REG_REVERSE_TIME = 3'd3;
    localparam logic [2:0] REG_SPIN_TIME    = 3'd4;
    localparam logic [2:0] REG_WEAVE_PERIOD = 3'd5;

    // Register reset values
    localparam logic [9:0]  IR_THRESHOLD_RST = 10'd500;
    localparam logic [15:0] START_DELAY_RST  = 16'd3000;
    localparam logic [15:0] TURN_TIME_RST    = 16'd1050;
    localparam logic [15:0] REVERSE_TIME_RST = 16'd500;
    localparam logic [15:0] SPIN_TIME_RST    = 16'd390;
    localparam logic [15:0] WEAVE_PERIOD_RST = 16'd500;

    // Sensor codes: {back_left, back_right, front_left, front_right, ir_r, ir_l, ir_c}
    localparam logic [6:0] CODE_SEARCH      = 7'd0;
    localparam logic [6:0] CODE_CHARGE      = 7'd1;
    localparam logic [6:0] CODE_TURN_LEFT   = 7'd2;
    localparam logic [6:0] CODE_VEER_LEFT   = 7'd3;
    localparam logic [6:0] CODE_TURN_RIGHT  = 7'd4;
    localparam logic [6:0] CODE_VEER_RIGHT  = 7'd5;
    localparam logic [6:0] CODE_BACK_FR     = 7'd8;
    localparam logic [6:0] CODE_STOP_FR     = 7'd9;
    localparam logic [6:0] CODE_BACK_FL     = 7'd16;
    localparam logic [6:0] CODE_STOP_FL     = 7'd17;
    localparam logic [6:0] CODE_BACK_BOTH   = 7'd24;
    localparam logic [6:0] CODE_STOP_LO     = 7'd25;
    localparam logic [6:0] CODE_STOP_HI     = 7'd29;

    function automatic t_duty duties(input logic [7:0] lf, input logic [7:0] lr,
                                     input logic [7:0] rf, input logic [7:0] rr);
        t_duty d;
        d[0] = lf;
        d[1] = lr;
        d[2] = rf;
        d[3] = rr;
        return d;
    endfunction

    // Spin in place: rightward drives left forward and right reverse
    function automatic t_duty spin_duty(input logic rightward);
        t_duty d;
        if (rightward) begin
            d = duties(DUTY_FULL, DUTY_OFF, DUTY_OFF, DUTY_FULL);
        end else begin
            d = duties(DUTY_OFF, DUTY_FULL, DUTY_FULL, DUTY_OFF);
        end
        return d;
    endfunction

endpackage

>>> src/reactive_drive_controller.sv
// Reactive drive controller. Each input word is one 1 ms tick with a sensor snapshot; each
// tick gives exactly one result word with the four motor PWM duties and the drive phase.
// The block arms when start_switch is first seen high, waits start_delay ticks, then picks
// a weave, charge, veer, stop, timed turn or timed reverse-then-spin from the IR threshold
// bits and the line bits. Throughput is one word per clock while the output is not stalled; a
// sensor word is taken into the input register, and its drive word is loaded into the result
// register after a single pass of decision logic that also updates the state.
// A stalled output lets one more word wait in the input register; after that intake stops
// until the result word is taken. Input ready stays low while reset is asserted.
// Configuration writes take effect at once and are meant to be made while the block is idle.
module reactive_drive_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Sensor words
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [0] start_switch, [10:1] ir_left, [20:11] ir_center, [30:21] ir_right,
    // [31] line_front_left, [32] line_front_right, [33] line_back_left,
    // [34] line_back_right, [35] left_bumper, [36] right_bumper, [39:37] zero
    input  logic [39:0] i_s_tdata,
    // Drive words
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] left_forward_duty, [15:8] left_reverse_duty, [23:16] right_forward_duty,
    // [31:24] right_reverse_duty, [34:32] phase, [39:35] zero
    output logic [39:0] o_m_tdata,
    // Configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data
);

    // Configuration registers
    logic [9:0]  r_ir_threshold;
    logic [15:0] r_start_delay;
    logic [15:0] r_turn_time;
    logic [15:0] r_reverse_time;
    logic [15:0] r_spin_time;
    logic [15:0] r_weave_period;

    // Input stage
    logic        r_in_vld;
    logic [39:0] r_in;
    logic        advance;

    // Drive state
    logic [31:0]        r_tick,      n_tick;
    logic               r_armed,     n_armed;
    logic [31:0]        r_arm_time,  n_arm_time;
    logic               r_left_fast, n_left_fast;
    logic [31:0]        r_flip_time, n_flip_time;
    rdc_pkg::t_phase    r_phase,     n_phase;
    logic [15:0]        r_elapsed,   n_elapsed;
    logic               r_spin_right, n_spin_right;
    rdc_pkg::t_duty     r_duty,      n_duty;
    logic               r_out_vld;

    // Decoded sensor word
    logic        sw, lfl, lfr, lbl, lbr, bump;
    logic        seen_l, seen_c, seen_r, any_ir;
    logic [6:0]  code;
    logic [15:0] elapsed_inc;
    logic [31:0] since_arm;
    logic        delay_done;
    logic        weave_due;
    logic        decide;

    // Configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ir_threshold <= rdc_pkg::IR_THRESHOLD_RST;
            r_start_delay  <= rdc_pkg::START_DELAY_RST;
            r_turn_time    <= rdc_pkg::TURN_TIME_RST;
            r_reverse_time <= rdc_pkg::REVERSE_TIME_RST;
            r_spin_time    <= rdc_pkg::SPIN_TIME_RST;
            r_weave_period <= rdc_pkg::WEAVE_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rdc_pkg::REG_IR_THRESHOLD: r_ir_threshold <= i_cfg_data[9:0];
                rdc_pkg::REG_START_DELAY:  r_start_delay  <= i_cfg_data;
                rdc_pkg::REG_TURN_TIME:    r_turn_time    <= i_cfg_data;
                rdc_pkg::REG_REVERSE_TIME: r_reverse_time <= i_cfg_data;
                rdc_pkg::REG_SPIN_TIME:    r_spin_time    <= i_cfg_data;
                rdc_pkg::REG_WEAVE_PERIOD: r_weave_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance a held word when the result register is free or being drained
    assign advance    = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = i_rst_n && (!r_in_vld || advance);

    // Capture the incoming word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in <= i_s_tdata;
        end
    end

    // Unpack sensors and threshold the IR samples
    assign sw     = r_in[0];
    assign seen_l = r_in[10:1]  > r_ir_threshold;
    assign seen_c = r_in[20:11] > r_ir_threshold;
    assign seen_r = r_in[30:21] > r_ir_threshold;
    assign lfl    = r_in[31];
    assign lfr    = r_in[32];
    assign lbl    = r_in[33];
    assign lbr    = r_in[34];
    assign bump   = r_in[35] | r_in[36];
    assign any_ir = seen_l | seen_c | seen_r;
    assign code   = {lbl, lbr, lfl, lfr, seen_r, seen_l, seen_c};

    // Timers: saturating maneuver count, wrapping tick differences
    assign elapsed_inc = (r_elapsed != 16'hFFFF) ? r_elapsed + 16'd1 : r_elapsed;
    assign since_arm   = r_armed ? r_tick - r_arm_time : 32'd0;
    assign delay_done  = since_arm >= {16'd0, r_start_delay};
    assign weave_due   = (r_tick - r_flip_time) >= {16'd0, r_weave_period};
    assign n_tick      = r_tick + 32'd1;

    // Next state for one tick
    always_comb begin
        n_armed      = r_armed;
        n_arm_time   = r_arm_time;
        n_left_fast  = r_left_fast;
        n_flip_time  = r_flip_time;
        n_phase      = r_phase;
        n_elapsed    = r_elapsed;
        n_spin_right = r_spin_right;
        n_duty       = r_duty;
        decide       = 1'b1;

        // Run a timed maneuver to its end
        case (r_phase)
            rdc_pkg::PH_TURN: begin
                n_elapsed = elapsed_inc;
                if (elapsed_inc >= r_turn_time || lfl || lfr || seen_c) begin
                    n_phase = rdc_pkg::PH_REACT;
                end else begin
                    decide = 1'b0;
                end
            end
            rdc_pkg::PH_REV: begin
                n_elapsed = elapsed_inc;
                decide    = 1'b0;
                if (elapsed_inc >= r_reverse_time || any_ir) begin
                    n_duty    = rdc_pkg::spin_duty(r_spin_right);
                    n_elapsed = 16'd0;
                    n_phase   = (r_spin_time != 16'd0 && !any_ir) ? rdc_pkg::PH_SPIN
                                                                   : rdc_pkg::PH_REACT;
                end
            end
            rdc_pkg::PH_SPIN: begin
                n_elapsed = elapsed_inc;
                if (elapsed_inc >= r_spin_time || any_ir) begin
                    n_phase = rdc_pkg::PH_REACT;
                end else begin
                    decide = 1'b0;
                end
            end
            default: ;
        endcase

        // Decide from the switch and the sensor code
        if (decide) begin
            if (sw) begin
                n_armed = 1'b1;
                if (!r_armed) begin
                    n_arm_time = r_tick;
                end
                if (delay_done) begin
                    n_phase = rdc_pkg::PH_REACT;
                    case (code) inside
                        rdc_pkg::CODE_SEARCH: begin
                            if (weave_due) begin
                                n_left_fast = !r_left_fast;
                                n_flip_time = r_tick;
                            end
                            if (bump) begin
                                n_duty = rdc_pkg::duties(rdc_pkg::DUTY_OFF, rdc_pkg::DUTY_OFF,
                                                         rdc_pkg::DUTY_OFF, rdc_pkg::DUTY_OFF);
                            end else if (n_left_fast) begin
                                n_duty = rdc_pkg::duties(rdc_pkg::DUTY_FULL, rdc_pkg::DUTY_OFF,
                                                         rdc_pkg::DUTY_WEAVE_SLOW,
                                                         rdc_pkg::DUTY_OFF);
                            end else begin
                                n_duty = rdc_pkg::duties(rdc_pkg::DUTY_WEAVE_SLOW,
                                                         rdc_pkg::DUTY_OFF,
                                                         rdc_pkg::DUTY_FULL, rdc_pkg::DUTY_OFF);
                            end
                        end
                        rdc_pkg::CODE_CHARGE: begin
                            n_duty = rdc_pkg::duties(rdc_pkg::DUTY_FULL, rdc_pkg::DUTY_OFF,
                                                     rdc_pkg::DUTY_FULL, rdc_pkg::DUTY_OFF);
                        end
                        rdc_pkg::CODE_VEER_LEFT: begin
                            n_duty = rdc_pkg::duties(rdc_pkg::DUTY_VEER_SLOW, rdc_pkg::DUTY_OFF,
                                                     rdc_pkg::DUTY_FULL, rdc_pkg::DUTY_OFF);
                        end
                        rdc_pkg::CODE_VEER_RIGHT: begin
                            n_duty = rdc_pkg::duties(rdc_pkg::DUTY_FULL, rdc_pkg::DUTY_OFF,
                                                     rdc_pkg::DUTY_VEER_SLOW,
                                                     rdc_pkg::DUTY_OFF);
                        end
                        rdc_pkg::CODE_TURN_LEFT, rdc_pkg::CODE_TURN_RIGHT: begin
                            n_duty    = rdc_pkg::spin_duty(code == rdc_pkg::CODE_TURN_RIGHT);
                            n_elapsed = 16'd0;
                            if (r_turn_time != 16'd0) begin
                                n_phase = rdc_pkg::PH_TURN;
                            end
                        end
                        rdc_pkg::CODE_BACK_FR, rdc_pkg::CODE_BACK_FL,
                        rdc_pkg::CODE_BACK_BOTH: begin
                            n_spin_right = (code != rdc_pkg::CODE_BACK_FL);
                            n_elapsed    = 16'd0;
                            if (r_reverse_time != 16'd0) begin
                                n_duty  = rdc_pkg::duties(rdc_pkg::DUTY_OFF, rdc_pkg::DUTY_FULL,
                                                          rdc_pkg::DUTY_OFF, rdc_pkg::DUTY_FULL);
                                n_phase = rdc_pkg::PH_REV;
                            end else begin
                                // Zero reverse time: go straight to the spin
                                n_duty  = rdc_pkg::spin_duty(n_spin_right);
                                n_phase = (r_spin_time != 16'd0 && !any_ir)
                                        ? rdc_pkg::PH_SPIN : rdc_pkg::PH_REACT;
                            end
                        end
                        rdc_pkg::CODE_STOP_FR, rdc_pkg::CODE_STOP_FL,
                        [rdc_pkg::CODE_STOP_LO:rdc_pkg::CODE_STOP_HI]: begin
                            n_duty = rdc_pkg::duties(rdc_pkg::DUTY_OFF, rdc_pkg::DUTY_OFF,
                                                     rdc_pkg::DUTY_OFF, rdc_pkg::DUTY_OFF);
                        end
                        default: ;
                    endcase
                end else begin
                    n_phase = rdc_pkg::PH_DELAY;
                end
            end else begin
                n_phase = rdc_pkg::PH_IDLE;
            end
        end
    end

    // Hold state and result; advance one tick per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick       <= 32'd0;
            r_armed      <= 1'b0;
            r_arm_time   <= 32'd0;
            r_left_fast  <= 1'b1;
            r_flip_time  <= 32'd0;
            r_phase      <= rdc_pkg::PH_IDLE;
            r_elapsed    <= 16'd0;
            r_spin_right <= 1'b0;
            r_duty       <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (advance) begin
                r_tick       <= n_tick;
                r_armed      <= n_armed;
                r_arm_time   <= n_arm_time;
                r_left_fast  <= n_left_fast;
                r_flip_time  <= n_flip_time;
                r_phase      <= n_phase;
                r_elapsed    <= n_elapsed;
                r_spin_right <= n_spin_right;
                r_duty       <= n_duty;
                r_out_vld    <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld    <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {5'd0, r_phase, r_duty};

endmodule

>>> src/rdc_checker.sv
`include "assert_macros.svh"

module rdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata
);

    logic        out_stall;
    logic        turn_shown;
    logic        rev_shown;
    logic        turn_duty_ok;
    logic        rev_duty_ok;

    assign out_stall  = o_m_tvalid && !i_m_tready;
    assign turn_shown = o_m_tvalid && (o_m_tdata[34:32] == rdc_pkg::PH_TURN);
    assign rev_shown  = o_m_tvalid && (o_m_tdata[34:32] == rdc_pkg::PH_REV);

    // A turn drives one side forward and the other in reverse at full duty
    assign turn_duty_ok =
        (o_m_tdata[31:0] == {rdc_pkg::DUTY_OFF, rdc_pkg::DUTY_FULL,
                             rdc_pkg::DUTY_FULL, rdc_pkg::DUTY_OFF}) ||
        (o_m_tdata[31:0] == {rdc_pkg::DUTY_FULL, rdc_pkg::DUTY_OFF,
                             rdc_pkg::DUTY_OFF, rdc_pkg::DUTY_FULL});

    // Backing away runs both reverse legs at full duty
    assign rev_duty_ok =
        o_m_tdata[31:0] == {rdc_pkg::DUTY_FULL, rdc_pkg::DUTY_OFF,
                            rdc_pkg::DUTY_FULL, rdc_pkg::DUTY_OFF};

    `RDC_ASSERT(a_out_hold, out_stall |=> o_m_tvalid && $stable(o_m_tdata), "word moved in stall")
    `RDC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_m_tvalid, "word shown after reset")
    `RDC_ASSERT(a_turn_duty, turn_shown |-> turn_duty_ok, "turn phase without turn duties")
    `RDC_ASSERT(a_rev_duty, rev_shown |-> rev_duty_ok, "reverse phase without reverse duties")

endmodule

bind reactive_drive_controller rdc_checker u_rdc_checker (.*);
